@@ rtl/core/brpd_pkg.sv @@
`timescale 1ns / 1ps

package brpd_pkg;

    // Ring size when the top level is not told otherwise
    localparam int unsigned DEPTH_DEFAULT = 4096;

    // Header: type byte, then big-endian 16-bit payload length
    localparam int unsigned HDR_BYTES = 3;

    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_POP_BYTE   = 2'd1,
        ACT_POP_HEADER = 2'd2,
        ACT_STATUS     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NO_PACKET = 2'd3
    } status_t;

endpackage

@@ rtl/core/byte_ring_packet_deframer_core.sv @@
`timescale 1ns / 1ps

// Results: push, status query and any refused request give their result in the cycle after
// acceptance; pop byte first passes FSM_POP_FILL, pop header FSM_HDR_R1, R2 and R3.
// Throughput: 1 request per cycle for push, query and refusals while m_tready takes each result;
// pop byte and pop header hold the input until the single read port has refilled the header window.
// Reset (aresetn low, synchronous): clear pointers, fill count and handshake state;
// the byte store is not cleared and needs no clearing pass.

module byte_ring_packet_deframer_core #(
    parameter int unsigned DEPTH = brpd_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] push_byte
    input  logic [1:0]  s_tuser,   // [1:0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] popped_byte, [15:8] packet_type,
                                   // [31:16] payload_length, [44:32] fill_count,
                                   // [45] ring_empty, [46] is_full, [47] packet_ready
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(DEPTH);       // ring pointer width
    localparam int unsigned CW = $clog2(DEPTH + 1);   // fill count width, holds DEPTH itself
    localparam int unsigned RW = ((CW > 16) ? CW : 16) + 1; // packet length compare width

    typedef enum logic [4:0] {
        FSM_IDLE     = 5'b00001,
        FSM_POP_FILL = 5'b00010,
        FSM_HDR_R1   = 5'b00100,
        FSM_HDR_R2   = 5'b01000,
        FSM_HDR_R3   = 5'b10000
    } fsm_t;

    // Advance a pointer round the ring by k places (k below DEPTH)
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p, input logic [1:0] k);
        logic [AW:0] sum;
        sum = {1'b0, p} + (AW+1)'(k);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Complete packet: header held and the whole payload behind it
    function automatic logic ready_of(input logic [CW-1:0] cnt, input logic [7:0] hi,
                                      input logic [7:0] lo);
        logic [RW-1:0] need;
        need = RW'({hi, lo}) + RW'(brpd_pkg::HDR_BYTES);
        return (cnt >= CW'(brpd_pkg::HDR_BYTES)) && (RW'(cnt) >= need);
    endfunction

    // Byte store: one write port, one registered read port
    logic [7:0]    byte_mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // Control state
    fsm_t          state_reg, state_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;

    // Header window: copies of the first three held bytes; beyond the fill count they are junk
    logic [7:0]    h0_reg, h0_next;
    logic [7:0]    h1_reg, h1_next;
    logic [7:0]    h2_reg, h2_next;

    // Result register
    brpd_pkg::status_t out_status_reg, out_status_next;
    logic [7:0]    out_popped_reg, out_popped_next;
    logic [7:0]    out_type_reg, out_type_next;
    logic [15:0]   out_len_reg, out_len_next;
    logic [12:0]   out_fill_reg, out_fill_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_full_reg, out_full_next;
    logic          out_ready_reg, out_ready_next;

    brpd_pkg::action_t act;
    logic          accept;
    logic          finish;

    assign act      = brpd_pkg::action_t'(s_tuser);
    // Take a request only while idle and the result slot is free or being emptied
    assign s_tready = (state_reg == FSM_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        h0_next         = h0_reg;
        h1_next         = h1_reg;
        h2_next         = h2_reg;
        out_status_next = out_status_reg;
        out_popped_next = out_popped_reg;
        out_type_next   = out_type_reg;
        out_len_next    = out_len_reg;
        mem_we          = 1'b0;
        finish          = 1'b0;
        // Default read: the byte that slides into the window after the current head
        rd_addr         = ring_add(rp_reg, 2'(brpd_pkg::HDR_BYTES));

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    out_status_next = brpd_pkg::ST_OK;
                    out_popped_next = 8'd0;
                    out_type_next   = 8'd0;
                    out_len_next    = 16'd0;
                    finish          = 1'b1;
                    case (act)
                        brpd_pkg::ACT_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                // Drop the byte
                                out_status_next = brpd_pkg::ST_OVERFLOW;
                            end else begin
                                mem_we     = 1'b1;
                                wp_next    = ring_add(wp_reg, 2'd1);
                                count_next = count_reg + CW'(1);
                                // Fill the header window directly while it is short
                                if (count_reg < CW'(brpd_pkg::HDR_BYTES)) begin
                                    case (count_reg[1:0])
                                        2'd0:    h0_next = s_tdata;
                                        2'd1:    h1_next = s_tdata;
                                        default: h2_next = s_tdata;
                                    endcase
                                end
                            end
                        end
                        brpd_pkg::ACT_POP_BYTE: begin
                            if (count_reg == CW'(0)) begin
                                out_status_next = brpd_pkg::ST_UNDERFLOW;
                            end else begin
                                out_popped_next = h0_reg;
                                rp_next         = ring_add(rp_reg, 2'd1);
                                count_next      = count_reg - CW'(1);
                                h0_next         = h1_reg;
                                h1_next         = h2_reg;
                                finish          = 1'b0;
                                state_next      = FSM_POP_FILL;
                            end
                        end
                        brpd_pkg::ACT_POP_HEADER: begin
                            if (!ready_of(count_reg, h1_reg, h2_reg)) begin
                                out_status_next = brpd_pkg::ST_NO_PACKET;
                            end else begin
                                out_type_next = h0_reg;
                                out_len_next  = {h1_reg, h2_reg};
                                rp_next       = ring_add(rp_reg, 2'(brpd_pkg::HDR_BYTES));
                                count_next    = count_reg - CW'(brpd_pkg::HDR_BYTES);
                                finish        = 1'b0;
                                state_next    = FSM_HDR_R1;
                            end
                        end
                        brpd_pkg::ACT_STATUS: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FSM_POP_FILL: begin
                h2_next    = rd_data_reg;
                finish     = 1'b1;
                state_next = FSM_IDLE;
            end
            FSM_HDR_R1: begin
                // Head byte of the new window arrives; request the next one
                h0_next    = rd_data_reg;
                rd_addr    = ring_add(rp_reg, 2'd1);
                state_next = FSM_HDR_R2;
            end
            FSM_HDR_R2: begin
                h1_next    = rd_data_reg;
                rd_addr    = ring_add(rp_reg, 2'd2);
                state_next = FSM_HDR_R3;
            end
            FSM_HDR_R3: begin
                h2_next    = rd_data_reg;
                finish     = 1'b1;
                state_next = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Flags describe the state after the request, taken from the next values
    always_comb begin
        out_fill_next  = out_fill_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;
        out_ready_next = out_ready_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        if (finish) begin
            out_fill_next  = 13'(count_next);
            out_empty_next = (count_next == CW'(0));
            out_full_next  = (count_next == CW'(DEPTH));
            out_ready_next = ready_of(count_next, h1_next, h2_next);
            m_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            rp_reg      <= '0;
            wp_reg      <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        h0_reg         <= h0_next;
        h1_reg         <= h1_next;
        h2_reg         <= h2_next;
        out_status_reg <= out_status_next;
        out_popped_reg <= out_popped_next;
        out_type_reg   <= out_type_next;
        out_len_reg    <= out_len_next;
        out_fill_reg   <= out_fill_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
        out_ready_reg  <= out_ready_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            byte_mem[wp_reg] <= s_tdata;
        end
        rd_data_reg <= byte_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_ready_reg, out_full_reg, out_empty_reg, out_fill_reg,
                       out_len_reg, out_type_reg, out_popped_reg};

`ifndef ASSERT_OFF
    // No result may be shown while a request is still being worked on
    a_no_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != FSM_IDLE) |-> !m_valid_reg)
        else $error("result valid while a request is in progress");

    // Pointers meet exactly when the ring is empty or full
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg == CW'(0)) || (count_reg == CW'(DEPTH))) |-> (wp_reg == rp_reg))
        else $error("pointers disagree with fill count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond ring size");

    // An accepted push into a ring with room grows the fill count by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == brpd_pkg::ACT_PUSH) && (count_reg != CW'(DEPTH)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not advance fill count");
`endif

endmodule
